>>> design/ptc_pkg.sv
// Shared types and constants for the pressure and temperature compensation block.
package ptc_pkg;

  typedef struct packed {
    logic [23:0] pressure_count;
    logic [23:0] temperature_count;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [18:0]        pressure_decimbar;
    logic               out_of_range;
  } out_t;

  typedef enum logic [2:0] {
    REG_PRESSURE_SENSITIVITY   = 3'd0,
    REG_PRESSURE_OFFSET        = 3'd1,
    REG_SENSITIVITY_TEMP_COEFF = 3'd2,
    REG_OFFSET_TEMP_COEFF      = 3'd3,
    REG_REFERENCE_TEMPERATURE  = 3'd4,
    REG_TEMPERATURE_COEFF      = 3'd5
  } reg_idx_t;

  localparam logic signed [18:0] TEMP_REF       = 19'sd2000;
  localparam logic signed [18:0] VTEMP_OFS      = 19'sd3500;
  localparam logic signed [18:0] TEMP_VLOW_EDGE = -19'sd1599;
  localparam logic signed [14:0] TEMP_MIN_CENTI = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX_CENTI = 15'sd8500;
  localparam logic signed [34:0] PRES_MAX_DECI  = 35'sd300000;

endpackage

>>> design/pressure_temp_compensation.sv
// Top level of the pressure and temperature compensation pipeline.
// The block takes one pair of raw pressure and temperature counts per cycle while in_ready is
// high and returns the compensated temperature in 0.01 degC and pressure in 0.1 mbar,
// second-order corrected and saturated to the sensor range. It is a twelve-stage pipeline
// with a valid bit in every stage; a stalled output holds its result while earlier stages
// keep filling any empty slots, so one request per cycle is sustained whenever the output
// side takes results. The six calibration words lie at byte addresses 0x00 to 0x14 of the
// register port and reset to zero; the user must write them only while the block holds no
// request, as the block itself does not enforce this.
module pressure_temp_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptc_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ptc_pkg::out_t      out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ptc_pkg::*;

  localparam int STAGES = 12;

  logic [15:0] pressure_sensitivity_r;
  logic [15:0] pressure_offset_r;
  logic [15:0] sensitivity_temp_coeff_r;
  logic [15:0] offset_temp_coeff_r;
  logic [15:0] reference_temperature_r;
  logic [15:0] temperature_coeff_r;
  reg_idx_t    reg_idx;
  logic        reg_wr;

  logic [STAGES:1] v_r;
  logic [STAGES:1] v_src;
  logic [STAGES:1] stage_en;

  logic signed [24:0] s1_dt_r, s1_dt_nxt;
  logic [23:0]        s1_d1_r;

  logic signed [40:0] s2_m3_r, s2_m3_nxt, s2_m4_r, s2_m4_nxt, s2_m6_r, s2_m6_nxt;
  logic signed [49:0] s2_sq_full;
  logic [47:0]        s2_sq_r;
  logic [23:0]        s2_d1_r;

  logic signed [40:0] s3_m3_adj, s3_m4_adj, s3_m6_adj;
  logic [49:0]        s3_tl3;
  logic signed [32:0] s3_q3_r;
  logic signed [33:0] s3_q4_r;
  logic signed [17:0] s3_q6_r;
  logic [16:0]        s3_tilo_r;
  logic [11:0]        s3_tihi_r;
  logic [23:0]        s3_d1_r;

  logic signed [34:0] s4_sens_r, s4_sens_nxt;
  logic signed [35:0] s4_off_r, s4_off_nxt;
  logic signed [18:0] s4_temp_r, s4_temp_nxt, s4_vtemp_r, s4_vtemp_nxt;
  logic signed [17:0] s4_dtemp_r;
  logic               s4_low_r, s4_low_nxt, s4_vlow_r, s4_vlow_nxt;
  logic [16:0]        s4_ti_r, s4_ti_nxt;
  logic [23:0]        s4_d1_r;

  logic signed [35:0] s5_dsq_full;
  logic signed [37:0] s5_vsq_full;
  logic [33:0]        s5_dsq_r;
  logic [35:0]        s5_vsq_r;
  logic signed [19:0] s5_t2_r, s5_t2_nxt;
  logic signed [34:0] s5_sens_r;
  logic signed [35:0] s5_off_r;
  logic               s5_low_r, s5_vlow_r;
  logic [23:0]        s5_d1_r;

  logic [35:0]        s6_d3_r, s6_d3_nxt;
  logic [36:0]        s6_d5_r, s6_d5_nxt;
  logic [38:0]        s6_v7_r, s6_v7_nxt;
  logic [35:0]        s6_vsq_r;
  logic [29:0]        s6_dsqh_r;
  logic               s6_low_r, s6_vlow_r;
  logic signed [34:0] s6_sens_r;
  logic signed [35:0] s6_off_r;
  logic signed [14:0] s6_t2c_r, s6_t2c_nxt;
  logic               s6_tsat_r, s6_tsat_nxt;
  logic [23:0]        s6_d1_r;

  logic [39:0]        s7_offi_r, s7_offi_nxt;
  logic [38:0]        s7_sensi_r, s7_sensi_nxt;
  logic signed [34:0] s7_sens_r;
  logic signed [35:0] s7_off_r;
  logic signed [14:0] s7_t2c_r;
  logic               s7_tsat_r;
  logic [23:0]        s7_d1_r;

  logic signed [41:0] s8_sc_r, s8_sc_nxt, s8_oc_r, s8_oc_nxt;
  logic signed [14:0] s8_t2c_r;
  logic               s8_tsat_r;
  logic [23:0]        s8_d1_r;

  logic [44:0]        s9_pl_r, s9_pl_nxt;
  logic signed [45:0] s9_ph_r, s9_ph_nxt;
  logic signed [41:0] s9_oc_r;
  logic signed [14:0] s9_t2c_r;
  logic               s9_tsat_r;

  logic signed [46:0] s10_qf_r, s10_qf_nxt;
  logic               s10_rnz_r;
  logic signed [41:0] s10_oc_r;
  logic signed [14:0] s10_t2c_r;
  logic               s10_tsat_r;

  logic signed [47:0] s11_x_r, s11_x_nxt;
  logic signed [14:0] s11_t2c_r;
  logic               s11_tsat_r;

  logic signed [47:0] s12_xa;
  logic signed [34:0] s12_p;
  out_t               s12_out_r, s12_out_nxt;

  // Register port.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressure_sensitivity_r   <= '0;
      pressure_offset_r        <= '0;
      sensitivity_temp_coeff_r <= '0;
      offset_temp_coeff_r      <= '0;
      reference_temperature_r  <= '0;
      temperature_coeff_r      <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_PRESSURE_SENSITIVITY:   pressure_sensitivity_r   <= pwdata[15:0];
        REG_PRESSURE_OFFSET:        pressure_offset_r        <= pwdata[15:0];
        REG_SENSITIVITY_TEMP_COEFF: sensitivity_temp_coeff_r <= pwdata[15:0];
        REG_OFFSET_TEMP_COEFF:      offset_temp_coeff_r      <= pwdata[15:0];
        REG_REFERENCE_TEMPERATURE:  reference_temperature_r  <= pwdata[15:0];
        REG_TEMPERATURE_COEFF:      temperature_coeff_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRESSURE_SENSITIVITY:   prdata = {16'b0, pressure_sensitivity_r};
      REG_PRESSURE_OFFSET:        prdata = {16'b0, pressure_offset_r};
      REG_SENSITIVITY_TEMP_COEFF: prdata = {16'b0, sensitivity_temp_coeff_r};
      REG_OFFSET_TEMP_COEFF:      prdata = {16'b0, offset_temp_coeff_r};
      REG_REFERENCE_TEMPERATURE:  prdata = {16'b0, reference_temperature_r};
      REG_TEMPERATURE_COEFF:      prdata = {16'b0, temperature_coeff_r};
      default:                    prdata = '0;
    endcase
  end

  // Pipeline control: a stage moves when it or any later stage is empty, or the output drains.
  for (genvar i = 1; i <= STAGES; i++) begin : g_en
    assign stage_en[i] = out_ready || !(&v_r[STAGES:i]);
  end

  assign v_src    = {v_r[STAGES-1:1], in_valid};
  assign in_ready = stage_en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 1; i <= STAGES; i++) begin
        if (stage_en[i]) begin
          v_r[i] <= v_src[i];
        end
      end
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_data  = s12_out_r;

  // Stage 1: temperature difference.
  assign s1_dt_nxt = $signed({1'b0, in_data.temperature_count})
                   - $signed({1'b0, reference_temperature_r, 8'b0});

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s1_dt_r <= s1_dt_nxt;
      s1_d1_r <= in_data.pressure_count;
    end
  end

  // Stage 2: coefficient products and the square of the difference.
  always_comb begin
    s2_m3_nxt  = 41'(s1_dt_r) * 41'($signed({1'b0, sensitivity_temp_coeff_r}));
    s2_m4_nxt  = 41'(s1_dt_r) * 41'($signed({1'b0, offset_temp_coeff_r}));
    s2_m6_nxt  = 41'(s1_dt_r) * 41'($signed({1'b0, temperature_coeff_r}));
    s2_sq_full = 50'(s1_dt_r) * 50'(s1_dt_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s2_m3_r <= s2_m3_nxt;
      s2_m4_r <= s2_m4_nxt;
      s2_m6_r <= s2_m6_nxt;
      s2_sq_r <= s2_sq_full[47:0];
      s2_d1_r <= s1_d1_r;
    end
  end

  // Stage 3: divisions by powers of two, rounded toward zero.
  always_comb begin
    s3_m3_adj = s2_m3_r + $signed({33'b0, {8{s2_m3_r[40]}}});
    s3_m4_adj = s2_m4_r + $signed({34'b0, {7{s2_m4_r[40]}}});
    s3_m6_adj = s2_m6_r + $signed({18'b0, {23{s2_m6_r[40]}}});
    s3_tl3    = {2'b0, s2_sq_r} + {1'b0, s2_sq_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s3_q3_r   <= $signed(s3_m3_adj[40:8]);
      s3_q4_r   <= $signed(s3_m4_adj[40:7]);
      s3_q6_r   <= $signed(s3_m6_adj[40:23]);
      s3_tilo_r <= s3_tl3[49:33];
      s3_tihi_r <= s2_sq_r[47:36];
      s3_d1_r   <= s2_d1_r;
    end
  end

  // Stage 4: first-order terms and band selection.
  always_comb begin
    s4_sens_nxt  = $signed({4'b0, pressure_sensitivity_r, 15'b0}) + 35'(s3_q3_r);
    s4_off_nxt   = $signed({4'b0, pressure_offset_r, 16'b0}) + 36'(s3_q4_r);
    s4_temp_nxt  = 19'(s3_q6_r) + TEMP_REF;
    s4_vtemp_nxt = 19'(s3_q6_r) + VTEMP_OFS;
    s4_low_nxt   = s4_temp_nxt < TEMP_REF;
    s4_vlow_nxt  = s4_temp_nxt < TEMP_VLOW_EDGE;
    s4_ti_nxt    = s4_low_nxt ? s3_tilo_r : {5'b0, s3_tihi_r};
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s4_sens_r  <= s4_sens_nxt;
      s4_off_r   <= s4_off_nxt;
      s4_temp_r  <= s4_temp_nxt;
      s4_dtemp_r <= s3_q6_r;
      s4_vtemp_r <= s4_vtemp_nxt;
      s4_low_r   <= s4_low_nxt;
      s4_vlow_r  <= s4_vlow_nxt;
      s4_ti_r    <= s4_ti_nxt;
      s4_d1_r    <= s3_d1_r;
    end
  end

  // Stage 5: squares for the second-order terms and the corrected temperature.
  always_comb begin
    s5_dsq_full = 36'(s4_dtemp_r) * 36'(s4_dtemp_r);
    s5_vsq_full = 38'(s4_vtemp_r) * 38'(s4_vtemp_r);
    s5_t2_nxt   = 20'(s4_temp_r) - $signed({3'b0, s4_ti_r});
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s5_dsq_r  <= s5_dsq_full[33:0];
      s5_vsq_r  <= s5_vsq_full[35:0];
      s5_t2_r   <= s5_t2_nxt;
      s5_sens_r <= s4_sens_r;
      s5_off_r  <= s4_off_r;
      s5_low_r  <= s4_low_r;
      s5_vlow_r <= s4_vlow_r;
      s5_d1_r   <= s4_d1_r;
    end
  end

  // Stage 6: small constant multiples and temperature saturation.
  always_comb begin
    s6_d3_nxt   = {2'b0, s5_dsq_r} + {1'b0, s5_dsq_r, 1'b0};
    s6_d5_nxt   = {3'b0, s5_dsq_r} + {1'b0, s5_dsq_r, 2'b0};
    s6_v7_nxt   = {s5_vsq_r, 3'b0} - {3'b0, s5_vsq_r};
    s6_t2c_nxt  = s5_t2_r[14:0];
    s6_tsat_nxt = 1'b0;
    if (s5_t2_r < 20'(TEMP_MIN_CENTI)) begin
      s6_t2c_nxt  = TEMP_MIN_CENTI;
      s6_tsat_nxt = 1'b1;
    end
    if (s5_t2_r > 20'(TEMP_MAX_CENTI)) begin
      s6_t2c_nxt  = TEMP_MAX_CENTI;
      s6_tsat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      s6_d3_r   <= s6_d3_nxt;
      s6_d5_r   <= s6_d5_nxt;
      s6_v7_r   <= s6_v7_nxt;
      s6_vsq_r  <= s5_vsq_r;
      s6_dsqh_r <= s5_dsq_r[33:4];
      s6_low_r  <= s5_low_r;
      s6_vlow_r <= s5_vlow_r;
      s6_sens_r <= s5_sens_r;
      s6_off_r  <= s5_off_r;
      s6_t2c_r  <= s6_t2c_nxt;
      s6_tsat_r <= s6_tsat_nxt;
      s6_d1_r   <= s5_d1_r;
    end
  end

  // Stage 7: second-order offset and sensitivity corrections.
  always_comb begin
    if (s6_low_r) begin
      s7_offi_nxt  = 40'(s6_d3_r[35:1]) + (s6_vlow_r ? 40'(s6_v7_r) : 40'(0));
      s7_sensi_nxt = 39'(s6_d5_r[36:3]) + (s6_vlow_r ? {1'b0, s6_vsq_r, 2'b0} : 39'(0));
    end else begin
      s7_offi_nxt  = 40'(s6_dsqh_r);
      s7_sensi_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      s7_offi_r  <= s7_offi_nxt;
      s7_sensi_r <= s7_sensi_nxt;
      s7_sens_r  <= s6_sens_r;
      s7_off_r   <= s6_off_r;
      s7_t2c_r   <= s6_t2c_r;
      s7_tsat_r  <= s6_tsat_r;
      s7_d1_r    <= s6_d1_r;
    end
  end

  // Stage 8: corrected sensitivity and offset.
  always_comb begin
    s8_sc_nxt = 42'(s7_sens_r) - $signed({3'b0, s7_sensi_r});
    s8_oc_nxt = 42'(s7_off_r) - $signed({2'b0, s7_offi_r});
  end

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      s8_sc_r   <= s8_sc_nxt;
      s8_oc_r   <= s8_oc_nxt;
      s8_t2c_r  <= s7_t2c_r;
      s8_tsat_r <= s7_tsat_r;
      s8_d1_r   <= s7_d1_r;
    end
  end

  // Stage 9: pressure count times sensitivity, as two partial products.
  always_comb begin
    s9_pl_nxt = 45'(s8_d1_r) * 45'(s8_sc_r[20:0]);
    s9_ph_nxt = 46'($signed({1'b0, s8_d1_r})) * 46'($signed(s8_sc_r[41:21]));
  end

  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      s9_pl_r   <= s9_pl_nxt;
      s9_ph_r   <= s9_ph_nxt;
      s9_oc_r   <= s8_oc_r;
      s9_t2c_r  <= s8_t2c_r;
      s9_tsat_r <= s8_tsat_r;
    end
  end

  // Stage 10: floor of the product over 2^21, with the remainder flag.
  assign s10_qf_nxt = 47'(s9_ph_r) + $signed({23'b0, s9_pl_r[44:21]});

  always_ff @(posedge clk) begin
    if (stage_en[10]) begin
      s10_qf_r   <= s10_qf_nxt;
      s10_rnz_r  <= |s9_pl_r[20:0];
      s10_oc_r   <= s9_oc_r;
      s10_t2c_r  <= s9_t2c_r;
      s10_tsat_r <= s9_tsat_r;
    end
  end

  // Stage 11: round the quotient toward zero and subtract the offset.
  assign s11_x_nxt = 48'(s10_qf_r) - 48'(s10_oc_r)
                   + $signed({47'b0, s10_qf_r[46] & s10_rnz_r});

  always_ff @(posedge clk) begin
    if (stage_en[11]) begin
      s11_x_r    <= s11_x_nxt;
      s11_t2c_r  <= s10_t2c_r;
      s11_tsat_r <= s10_tsat_r;
    end
  end

  // Stage 12: final division toward zero and pressure saturation.
  always_comb begin
    s12_xa                        = s11_x_r + $signed({35'b0, {13{s11_x_r[47]}}});
    s12_p                         = $signed(s12_xa[47:13]);
    s12_out_nxt.temperature_centi = s11_t2c_r;
    s12_out_nxt.pressure_decimbar = s12_p[18:0];
    s12_out_nxt.out_of_range      = s11_tsat_r;
    if (s12_p < 35'sd0) begin
      s12_out_nxt.pressure_decimbar = '0;
      s12_out_nxt.out_of_range      = 1'b1;
    end
    if (s12_p > PRES_MAX_DECI) begin
      s12_out_nxt.pressure_decimbar = PRES_MAX_DECI[18:0];
      s12_out_nxt.out_of_range      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[12]) begin
      s12_out_r <= s12_out_nxt;
    end
  end

endmodule
